[hdl/fdse_pkg.sv]
`timescale 1ns / 1ps

package fdse_pkg;

    localparam int DATA_W          = 32;
    localparam int CNT_W           = $clog2(DATA_W);
    localparam int STACK_DEPTH_DEF = 64;

    typedef enum logic [3:0] {
        K_LIT     = 4'd0,
        K_ADD     = 4'd1,
        K_SUB     = 4'd2,
        K_MUL     = 4'd3,
        K_DIV     = 4'd4,
        K_PRINT   = 4'd5,
        K_DUMP    = 4'd6,
        K_DUP     = 4'd7,
        K_DROP    = 4'd8,
        K_SWAP    = 4'd9,
        K_OVER    = 4'd10,
        K_ROT     = 4'd11,
        K_UNKNOWN = 4'd12
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_DIV_ZERO  = 3'd3,
        ST_UNKNOWN   = 3'd4
    } t_status;

    // HOLD keeps, POP takes the deeper neighbor, PUSH takes the shallower one
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_POP,
        CELL_PUSH,
        CELL_LOAD
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [DATA_W-1:0]   data;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DUMP
    } t_state;

endpackage

[hdl/forth_data_stack_executor_top.sv]
`timescale 1ns / 1ps
// A new item is accepted only while idle, so it waits until the previous one
// has given its last result. Div runs a serial divider (one quotient bit per
// cycle); a non-empty dump rotates the cell row once around, giving one result
// per stack entry, the last of them under o_last.
// Synchronous active-low reset empties the stack; cell contents are not cleared.
// The receiver cannot stall; each result is shown for one cycle under o_strobe.

module forth_data_stack_executor_top #(
    parameter int STACK_DEPTH = fdse_pkg::STACK_DEPTH_DEF,
    parameter int DW          = $clog2(STACK_DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [3:0]                         i_kind,
    input  logic signed [fdse_pkg::DATA_W-1:0] i_literal,
    output logic                               o_strobe,
    output logic [2:0]                         o_status,
    output logic signed [fdse_pkg::DATA_W-1:0] o_value,
    output logic                               o_has_value,
    output logic [DW-1:0]                      o_depth,
    output logic                               o_last
);
    import fdse_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH);

    t_state            r_state, n_state;
    logic [DW-1:0]     r_depth, n_depth;
    logic [CW-1:0]     r_cnt,   n_cnt;
    t_kind             r_kind,  n_kind;
    logic [DATA_W-1:0] r_lit,   n_lit;
    logic              r_ostb,  n_ostb;
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_value, n_value;
    logic              r_has,   n_has;
    logic              r_last,  n_last;

    logic [DATA_W-1:0] w_cell [STACK_DEPTH];
    t_cell_ctrl        w_ctrl [STACK_DEPTH];
    t_cell_op          w_common;
    logic              w_ov0, w_ov1, w_ov2;
    logic [DATA_W-1:0] w_d0, w_d1, w_d2;
    logic [1:0]        w_need;
    logic              w_unknown;
    logic              w_full;
    logic [DATA_W-1:0] w_sum, w_diff, w_prod;
    logic              w_div_start, w_div_done;
    logic [DATA_W-1:0] w_quot;
    logic              w_accept;
    logic              w_dump_hit;

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            fdse_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl[gi]),
                .i_deeper    (w_cell[(gi + 1) % STACK_DEPTH]),
                .i_shallower (w_cell[(gi + STACK_DEPTH - 1) % STACK_DEPTH]),
                .o_data      (w_cell[gi])
            );
        end
    endgenerate

    fdse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_cell[1]),
        .i_divisor  (w_cell[0]),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && (r_state == S_IDLE);
    assign w_full   = (r_depth == DW'(STACK_DEPTH));
    assign w_sum    = w_cell[1] + w_cell[0];
    assign w_diff   = w_cell[1] - w_cell[0];
    assign w_prod   = w_cell[1] * w_cell[0];
    // cell STACK_DEPTH-1 holds stack index STACK_DEPTH - 1 - cnt during the rotation
    assign w_dump_hit = ((DW + 1)'(r_cnt) + (DW + 1)'(r_depth)) >= (DW + 1)'(STACK_DEPTH);

    always_comb begin
        w_need    = 2'd0;
        w_unknown = 1'b0;
        case (r_kind)
            K_LIT, K_DUMP:                          w_need = 2'd0;
            K_PRINT, K_DUP, K_DROP:                 w_need = 2'd1;
            K_ADD, K_SUB, K_MUL, K_DIV, K_SWAP, K_OVER: w_need = 2'd2;
            K_ROT:                                  w_need = 2'd3;
            K_UNKNOWN:                              w_unknown = 1'b1;
            default:                                w_unknown = 1'b1;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_cnt       = r_cnt;
        n_kind      = r_kind;
        n_lit       = r_lit;
        n_ostb      = 1'b0;
        n_status    = ST_OK;
        n_value     = '0;
        n_has       = 1'b0;
        n_last      = 1'b0;
        w_div_start = 1'b0;
        w_common    = CELL_HOLD;
        w_ov0       = 1'b0;
        w_ov1       = 1'b0;
        w_ov2       = 1'b0;
        w_d0        = '0;
        w_d1        = '0;
        w_d2        = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                    n_kind  = t_kind'(i_kind);
                    n_lit   = i_literal;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_ostb  = 1'b1;
                n_last  = 1'b1;
                if (w_unknown) begin
                    n_status = ST_UNKNOWN;
                end else if (r_depth < DW'(w_need)) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    case (r_kind)
                        K_LIT, K_DUP, K_OVER: begin
                            if (w_full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                w_common = CELL_PUSH;
                                w_ov0    = 1'b1;
                                n_depth  = r_depth + 1'b1;
                                if (r_kind == K_LIT) begin
                                    w_d0 = r_lit;
                                end else if (r_kind == K_DUP) begin
                                    w_d0 = w_cell[0];
                                end else begin
                                    w_d0 = w_cell[1];
                                end
                            end
                        end
                        K_ADD, K_SUB, K_MUL: begin
                            w_common = CELL_POP;
                            w_ov0    = 1'b1;
                            n_depth  = r_depth - 1'b1;
                            if (r_kind == K_ADD) begin
                                w_d0 = w_sum;
                            end else if (r_kind == K_SUB) begin
                                w_d0 = w_diff;
                            end else begin
                                w_d0 = w_prod;
                            end
                        end
                        K_DIV: begin
                            if (w_cell[0] == '0) begin
                                w_common = CELL_POP;
                                w_ov0    = 1'b1;
                                w_d0     = '0;
                                n_depth  = r_depth - 1'b1;
                                n_status = ST_DIV_ZERO;
                            end else begin
                                w_div_start = 1'b1;
                                n_state     = S_DIV;
                                n_ostb      = 1'b0;
                                n_last      = 1'b0;
                            end
                        end
                        K_PRINT: begin
                            w_common = CELL_POP;
                            n_value  = w_cell[0];
                            n_has    = 1'b1;
                            n_depth  = r_depth - 1'b1;
                        end
                        K_DROP: begin
                            w_common = CELL_POP;
                            n_depth  = r_depth - 1'b1;
                        end
                        K_DUMP: begin
                            if (r_depth != '0) begin
                                n_state = S_DUMP;
                                n_cnt   = '0;
                                n_ostb  = 1'b0;
                                n_last  = 1'b0;
                            end
                        end
                        K_SWAP: begin
                            w_ov0 = 1'b1;
                            w_d0  = w_cell[1];
                            w_ov1 = 1'b1;
                            w_d1  = w_cell[0];
                        end
                        K_ROT: begin
                            w_ov0 = 1'b1;
                            w_d0  = w_cell[2];
                            w_ov1 = 1'b1;
                            w_d1  = w_cell[0];
                            w_ov2 = 1'b1;
                            w_d2  = w_cell[1];
                        end
                        default: begin
                            n_status = ST_UNKNOWN;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    w_common = CELL_POP;
                    w_ov0    = 1'b1;
                    w_d0     = w_quot;
                    n_depth  = r_depth - 1'b1;
                    n_ostb   = 1'b1;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_DUMP: begin
                w_common = CELL_PUSH;
                if (w_dump_hit) begin
                    n_ostb  = 1'b1;
                    n_value = w_cell[STACK_DEPTH-1];
                    n_has   = 1'b1;
                end
                if (r_cnt == CW'(STACK_DEPTH - 1)) begin
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
            w_ctrl[i].op   = w_common;
            w_ctrl[i].data = '0;
        end
        if (w_ov0) begin
            w_ctrl[0].op   = CELL_LOAD;
            w_ctrl[0].data = w_d0;
        end
        if (w_ov1) begin
            w_ctrl[1].op   = CELL_LOAD;
            w_ctrl[1].data = w_d1;
        end
        if (w_ov2) begin
            w_ctrl[2].op   = CELL_LOAD;
            w_ctrl[2].data = w_d2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_cnt   <= '0;
            r_ostb  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_cnt   <= n_cnt;
            r_ostb  <= n_ostb;
        end
        r_kind   <= n_kind;
        r_lit    <= n_lit;
        r_status <= n_status;
        r_value  <= n_value;
        r_has    <= n_has;
        r_last   <= n_last;
    end

    assign o_strobe    = r_ostb;
    assign o_status    = r_status;
    assign o_value     = r_value;
    assign o_has_value = r_has;
    assign o_depth     = r_depth;
    assign o_last      = r_last;

endmodule

[hdl/fdse_cell.sv]
`timescale 1ns / 1ps

module fdse_cell (
    input  logic                       i_clk,
    input  fdse_pkg::t_cell_ctrl       i_ctrl,
    input  logic [fdse_pkg::DATA_W-1:0] i_deeper,
    input  logic [fdse_pkg::DATA_W-1:0] i_shallower,
    output logic [fdse_pkg::DATA_W-1:0] o_data
);
    import fdse_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        case (i_ctrl.op)
            CELL_POP:  n_data = i_deeper;
            CELL_PUSH: n_data = i_shallower;
            CELL_LOAD: n_data = i_ctrl.data;
            default:   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[hdl/fdse_div.sv]
`timescale 1ns / 1ps

module fdse_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fdse_pkg::DATA_W-1:0] i_dividend,
    input  logic [fdse_pkg::DATA_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [fdse_pkg::DATA_W-1:0] o_quot
);
    import fdse_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic              r_neg,  n_neg;
    logic [DATA_W-1:0] r_quo,  n_quo;
    logic [DATA_W-1:0] r_rem,  n_rem;
    logic [DATA_W-1:0] r_dvs,  n_dvs;
    logic [DATA_W:0]   w_sh;
    logic [DATA_W:0]   w_diff;

    assign w_sh   = {r_rem, r_quo[DATA_W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_neg  = i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            n_quo  = i_dividend[DATA_W-1] ? -i_dividend : i_dividend;
            n_dvs  = i_divisor[DATA_W-1] ? -i_divisor : i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            if (!w_diff[DATA_W]) begin
                n_rem = w_diff[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                n_rem = w_sh[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DATA_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_neg <= n_neg;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -r_quo : r_quo;

endmodule

[hdl/fdse_checker.sv]
`timescale 1ns / 1ps

module fdse_checker #(
    parameter int STACK_DEPTH = fdse_pkg::STACK_DEPTH_DEF,
    parameter int DW          = $clog2(STACK_DEPTH + 1)
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_strobe,
    input logic [2:0]                  o_status,
    input logic [fdse_pkg::DATA_W-1:0] o_value,
    input logic                        o_has_value,
    input logic [DW-1:0]               o_depth,
    input logic                        o_last
);
    import fdse_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("no busy after accepted item");

    a_dump_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy ##1 o_strobe)
        else $error("dump results not contiguous");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_has_value |-> o_value == '0)
        else $error("value set without has_value");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_depth <= DW'(STACK_DEPTH))
        else $error("depth beyond stack size");

    a_err_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != ST_OK) |-> !o_has_value && o_last)
        else $error("error result carries value or is not last");

endmodule

bind forth_data_stack_executor_top fdse_checker #(
    .STACK_DEPTH (STACK_DEPTH),
    .DW          (DW)
) u_fdse_checker (.*);
